@@ rtl/fpc_pkg.sv @@
`default_nettype none

package fpc_pkg;

    // Pixel store geometry
    localparam int PIXELS   = 1024;
    localparam int STORE_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // Fixed field widths
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 10;
    localparam int PACK_W  = 16;
    localparam int CFG_W   = 5;
    localparam int REGIDX_W = 3;

    // Register indexes on the configuration port
    typedef enum logic [REGIDX_W-1:0] {
        REG_UPPER_FIRST_BIT = 3'd0,
        REG_UPPER_WIDTH     = 3'd1,
        REG_LOWER_FIRST_BIT = 3'd2,
        REG_LOWER_WIDTH     = 3'd3,
        REG_UPPER_COMBINE   = 3'd4,
        REG_LOWER_COMBINE   = 3'd5,
        REG_PAIR_FRAMES     = 3'd6
    } reg_index_t;

    // Combine codes; the unused code behaves as keep newest
    localparam logic [1:0] COMB_KEEP = 2'd0;
    localparam logic [1:0] COMB_SUM  = 2'd1;
    localparam logic [1:0] COMB_MEAN = 2'd2;

    typedef struct packed {
        logic [4:0] upper_first_bit;
        logic [4:0] upper_width;
        logic [4:0] lower_first_bit;
        logic [4:0] lower_width;
        logic [1:0] upper_combine;
        logic [1:0] lower_combine;
        logic       pair_frames;
    } cfg_t;

    // Fields pulled out of one word, plus the masks that place them
    typedef struct packed {
        logic [PACK_W-1:0] upper;
        logic [PACK_W-1:0] lower;
        logic [PACK_W-1:0] upper_mask;
        logic [PACK_W-1:0] lower_mask;
    } fields_t;

endpackage

`default_nettype wire

@@ rtl/fpc_in_if.sv @@
`default_nettype none

interface fpc_in_if
    import fpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  sample_word;
    logic [INDEX_W-1:0] pixel_index;
    logic               frame_last;

    modport source (output valid, output sample_word, output pixel_index,
                    output frame_last, input ready);
    modport sink   (input valid, input sample_word, input pixel_index,
                    input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/fpc_out_if.sv @@
`default_nettype none

interface fpc_out_if
    import fpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PACK_W-1:0]  out_sample;
    logic [INDEX_W-1:0] out_index;
    logic               out_last;

    modport source (output valid, output out_sample, output out_index,
                    output out_last, input ready);
    modport sink   (input valid, input out_sample, input out_index,
                    input out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/frame_pair_field_coadder.sv @@
`default_nettype none

// Frame pair field coadder.
// samples: one beat per pixel (sample_word, pixel_index, frame_last).
// results: one beat per pixel of an output frame (out_sample, out_index,
// out_last). With pair_frames set, the first frame of each pair is written
// to the pixel store and gives no beat; each pixel of the second frame is
// combined field by field with its stored value. With pair_frames clear,
// every pixel comes out packed but uncombined.
// Path: an accepted beat is registered in the combine stage, then in the output register.
// Throughput: one beat per cycle while results are accepted; the single-port
// pixel store is written (first frame) or read (second frame) at most once per beat.
// Pipeline: accept stage (extract, store write or read issue), combine
// stage (store read data arrives), output register.
// Reset: configuration returns to its defaults, the pair phase returns to
// the first frame, pipeline empties; store contents stay undefined until
// written. A stall on results holds the output register and the combine
// stage; samples keep flowing while a free stage remains.
// Configuration: cfg_we writes cfg_data to register cfg_index; write only
// while the block is idle.
module frame_pair_field_coadder
    import fpc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [REGIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    fpc_in_if.sink                   samples,
    fpc_out_if.source                results
);

    cfg_t cfg_reg;

    // Pair phase: high while the current frame is the second of a pair
    logic sop_reg;

    // Combine stage
    logic               s1_valid_reg;
    logic               s1_paired_reg;
    logic               s1_in_range_reg;
    logic [PACK_W-1:0]  s1_upper_reg;
    logic [PACK_W-1:0]  s1_lower_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic               s1_last_reg;

    // Output register
    logic               out_valid_reg;
    logic [PACK_W-1:0]  out_sample_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_last_reg;

    // Pixel store
    logic [PACK_W-1:0]   store_mem [PIXELS];
    logic [PACK_W-1:0]   rd_data_reg;
    logic [STORE_AW-1:0] store_addr;
    logic                in_range;
    logic                store_we;
    logic                store_re;

    fields_t     fields;
    logic        in_fire;
    logic        out_advance;
    logic        s1_advance;
    logic        emits;
    logic        sop_next;
    logic [PACK_W-1:0] old_value;
    logic [PACK_W-1:0] comb_upper;
    logic [PACK_W-1:0] comb_lower;
    logic [PACK_W-1:0] out_sample_next;

    function automatic logic [PACK_W-1:0] combine_field(
        input logic [1:0]        how,
        input logic [PACK_W-1:0] cur,
        input logic [PACK_W-1:0] old,
        input logic [PACK_W-1:0] mask
    );
        logic [PACK_W:0] sum;
        sum = {1'b0, cur} + {1'b0, old & mask};
        case (how)
            COMB_SUM:  combine_field = sum[PACK_W-1:0] & mask;
            COMB_MEAN: combine_field = sum[PACK_W:1] & mask;
            default:   combine_field = cur;
        endcase
    endfunction

    fpc_field_extract u_extract (
        .word   (samples.sample_word),
        .cfg    (cfg_reg),
        .fields (fields)
    );

    // ---------------------------------------------------------------
    // Handshake: output register drains, combine stage follows it,
    // accept a new beat whenever the combine stage is free to load.
    // ---------------------------------------------------------------
    assign out_advance   = !out_valid_reg || results.ready;
    assign s1_advance    = !s1_valid_reg || out_advance;
    assign samples.ready = s1_advance;
    assign in_fire       = samples.valid && samples.ready;

    // A beat gives a result unless it is a first-frame pixel of a pair
    assign emits = !cfg_reg.pair_frames || sop_reg;

    assign in_range   = 32'(samples.pixel_index) < 32'(PIXELS);
    assign store_addr = STORE_AW'(samples.pixel_index);
    assign store_we   = in_fire && cfg_reg.pair_frames && !sop_reg && in_range;
    assign store_re   = in_fire && cfg_reg.pair_frames && sop_reg;

    // Next pair phase
    always_comb
    begin
        sop_next = sop_reg;
        if (!cfg_reg.pair_frames)
        begin
            sop_next = 1'b0;
        end
        else if (samples.frame_last)
        begin
            sop_next = !sop_reg;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_first_bit <= 5'd16;
            cfg_reg.upper_width     <= 5'd16;
            cfg_reg.lower_first_bit <= 5'd0;
            cfg_reg.lower_width     <= 5'd0;
            cfg_reg.upper_combine   <= COMB_KEEP;
            cfg_reg.lower_combine   <= COMB_KEEP;
            cfg_reg.pair_frames     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UPPER_FIRST_BIT: cfg_reg.upper_first_bit <= cfg_data;
                REG_UPPER_WIDTH:     cfg_reg.upper_width     <= cfg_data;
                REG_LOWER_FIRST_BIT: cfg_reg.lower_first_bit <= cfg_data;
                REG_LOWER_WIDTH:     cfg_reg.lower_width     <= cfg_data;
                REG_UPPER_COMBINE:   cfg_reg.upper_combine   <= cfg_data[1:0];
                REG_LOWER_COMBINE:   cfg_reg.lower_combine   <= cfg_data[1:0];
                REG_PAIR_FRAMES:     cfg_reg.pair_frames     <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pixel store: at most one access per beat, read data registered. A read
    // only happens in the second frame, so it never meets a write in
    // the same cycle, and a write from the previous cycle is already in.
    // Read data holds while the combine stage stalls since no beat is
    // accepted then.
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_addr] <= fields.upper | fields.lower;
        end
        if (store_re)
        begin
            rd_data_reg <= store_mem[store_addr];
        end
    end

    // ---------------------------------------------------------------
    // Accept stage -> combine stage
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sop_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                sop_reg <= sop_next;
            end
            if (s1_advance)
            begin
                s1_valid_reg <= in_fire && emits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_paired_reg   <= cfg_reg.pair_frames;
            s1_in_range_reg <= in_range;
            s1_upper_reg    <= fields.upper;
            s1_lower_reg    <= fields.lower;
            s1_index_reg    <= samples.pixel_index;
            s1_last_reg     <= samples.frame_last;
        end
    end

    // ---------------------------------------------------------------
    // Combine stage: out-of-range pixels combine with zero. Masks come straight from
    // configuration; the user must keep it static while beats flow (not enforced).
    // ---------------------------------------------------------------
    assign old_value  = s1_in_range_reg ? rd_data_reg : '0;
    assign comb_upper = combine_field(cfg_reg.upper_combine, s1_upper_reg,
                                      old_value, fields.upper_mask);
    assign comb_lower = combine_field(cfg_reg.lower_combine, s1_lower_reg,
                                      old_value, fields.lower_mask);
    assign out_sample_next = s1_paired_reg ? (comb_upper | comb_lower)
                                           : (s1_upper_reg | s1_lower_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            out_sample_reg <= out_sample_next;
            out_index_reg  <= s1_index_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_sample = out_sample_reg;
    assign results.out_index  = out_index_reg;
    assign results.out_last   = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_first_frame_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cfg_reg.pair_frames && !sop_reg |=> !s1_valid_reg)
        else $error("first-frame pixel reached the combine stage");

    a_unpaired_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !cfg_reg.pair_frames |=> !sop_reg)
        else $error("pair phase set while pairing is off");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_advance |=> s1_valid_reg && $stable(s1_index_reg))
        else $error("combine stage lost its beat during a stall");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a beat in the combine stage");

endmodule

`default_nettype wire

@@ rtl/fpc_field_extract.sv @@
`default_nettype none

module fpc_field_extract
    import fpc_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    input  wire cfg_t              cfg,
    output fields_t                fields
);

    logic [4:0]        upper_w;
    logic [4:0]        lower_w;
    logic [WORD_W-1:0] upper_fmask;
    logic [WORD_W-1:0] lower_fmask;
    logic [WORD_W-1:0] upper_placed;
    logic [WORD_W-1:0] upper_mask_placed;
    logic [WORD_W-1:0] lower_raw;

    // Saturate widths at sixteen
    assign upper_w = (cfg.upper_width > 5'd16) ? 5'd16 : cfg.upper_width;
    assign lower_w = (cfg.lower_width > 5'd16) ? 5'd16 : cfg.lower_width;

    assign upper_fmask = (WORD_W'(1) << upper_w) - WORD_W'(1);
    assign lower_fmask = (WORD_W'(1) << lower_w) - WORD_W'(1);

    // Upper field always sits right above the lower field's width
    assign upper_placed      = ((word >> cfg.upper_first_bit) & upper_fmask) << lower_w;
    assign upper_mask_placed = upper_fmask << lower_w;
    assign lower_raw         = (word >> cfg.lower_first_bit) & lower_fmask;

    assign fields.upper      = upper_placed[PACK_W-1:0];
    assign fields.lower      = lower_raw[PACK_W-1:0];
    assign fields.upper_mask = upper_mask_placed[PACK_W-1:0];
    assign fields.lower_mask = lower_fmask[PACK_W-1:0];

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

// Self-checking bench for frame_pair_field_coadder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpc_pkg::*;

    // The fourth combine code has no name in the package; it behaves as keep newest
    localparam logic [1:0] COMB_SPARE = 2'd3;

    // Pipeline is two deep; give it a little extra before touching registers
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_SAMPLES = 550;
    localparam int N_PLAN         = 46;

    typedef struct packed {
        logic [PACK_W-1:0]  sample;
        logic [INDEX_W-1:0] index;
        logic               last;
    } pixel_result_t;

    // One row of the directed sequence: either a register write or a pixel beat.
    // A pixel row with typed set carries its packed result written out by hand.
    typedef struct packed {
        logic               is_write;
        reg_index_t         wr_reg;
        logic [CFG_W-1:0]   wr_val;
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] pix;
        logic               last;
        logic               typed;
        logic [PACK_W-1:0]  want;
    } plan_row_t;

    localparam reg_index_t NO_REG = REG_UPPER_FIRST_BIT;

    localparam plan_row_t PLAN [0:N_PLAN-1] = '{
        // Reset settings: upper field is word[31:16], no lower field, keep newest.
        // First frame goes to the store, second frame comes out as is.
        '{1'b0, NO_REG, 5'd0, 32'hABCD_1234, 10'd0,    1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h1111_0000, 10'd0,    1'b0, 1'b1, 16'h1111},
        '{1'b0, NO_REG, 5'd0, 32'h0000_FFFF, 10'd1023, 1'b1, 1'b1, 16'h0000},
        // Two byte fields, upper summed (wraps), lower averaged
        '{1'b1, REG_UPPER_FIRST_BIT, 5'd24, 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_UPPER_WIDTH,     5'd8,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_FIRST_BIT, 5'd0,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_WIDTH,     5'd8,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_UPPER_COMBINE,   CFG_W'(COMB_SUM),  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_COMBINE,   CFG_W'(COMB_MEAN), 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b0, NO_REG, 5'd0, 32'hFF00_00FF, 10'd5, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h8000_0001, 10'd6, 1'b1, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h0100_0001, 10'd5, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h8000_0003, 10'd6, 1'b1, 1'b0, 16'h0000},
        // Swap the operations between the fields; all-ones against all-zeros
        '{1'b1, REG_UPPER_COMBINE,   CFG_W'(COMB_MEAN), 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_COMBINE,   CFG_W'(COMB_SUM),  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b0, NO_REG, 5'd0, 32'hFFFF_FFFF, 10'd7, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h0000_0000, 10'd8, 1'b1, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h0000_0000, 10'd7, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'hFFFF_FFFF, 10'd8, 1'b1, 1'b0, 16'h0000},
        // Widths past sixteen saturate, top start bits, spare combine code
        '{1'b1, REG_UPPER_FIRST_BIT, 5'd31, 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_UPPER_WIDTH,     5'd31, 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_FIRST_BIT, 5'd31, 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_WIDTH,     5'd20, 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_UPPER_COMBINE,   CFG_W'(COMB_SPARE), 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_COMBINE,   CFG_W'(COMB_SPARE), 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b0, NO_REG, 5'd0, 32'h8000_0000, 10'd512, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h7FFF_FFFF, 10'd341, 1'b1, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h8000_0000, 10'd512, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h5555_5555, 10'd341, 1'b1, 1'b0, 16'h0000},
        // Upper field starts below the lower width: it still lands at bit 8
        '{1'b1, REG_UPPER_FIRST_BIT, 5'd2,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_UPPER_WIDTH,     5'd4,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_FIRST_BIT, 5'd0,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_WIDTH,     5'd8,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_UPPER_COMBINE,   CFG_W'(COMB_SUM),  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_COMBINE,   CFG_W'(COMB_KEEP), 32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b0, NO_REG, 5'd0, 32'h0000_00FF, 10'd682, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'hFFFF_FF00, 10'd255, 1'b1, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h0000_003C, 10'd682, 1'b0, 1'b0, 16'h0000},
        '{1'b0, NO_REG, 5'd0, 32'h0000_0FF0, 10'd255, 1'b1, 1'b0, 16'h0000},
        // Pairing off: every beat comes out packed, no combining
        '{1'b1, REG_PAIR_FRAMES,     5'd0,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b0, NO_REG, 5'd0, 32'h0000_003C, 10'd1,    1'b0, 1'b1, 16'h0F3C},
        '{1'b0, NO_REG, 5'd0, 32'hFFFF_FFFF, 10'd1022, 1'b1, 1'b1, 16'h0FFF},
        // Both widths zero: nothing survives the packing
        '{1'b1, REG_UPPER_WIDTH,     5'd0,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b1, REG_LOWER_WIDTH,     5'd0,  32'h0, 10'd0, 1'b0, 1'b0, 16'h0},
        '{1'b0, NO_REG, 5'd0, 32'hFFFF_FFFF, 10'd3, 1'b1, 1'b1, 16'h0000}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [REGIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    fpc_in_if  in_bus ();
    fpc_out_if out_bus ();

    frame_pair_field_coadder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (in_bus),
        .results   (out_bus)
    );

    // Shadow of the block: its registers, pair phase and per-pixel first-frame store
    cfg_t              shadow_cfg;
    bit                pair_second;
    logic [PACK_W-1:0] pixel_mem [PIXELS];
    bit                pix_stored [PIXELS];
    int                stored_list [$];

    pixel_result_t     coadd_due_q [$];

    int fails     = 0;
    int fed_count = 0;
    bit feed_quiet = 1'b0;
    bit sink_quiet = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] merge_field(logic [1:0] how, logic [31:0] cur,
                                                logic [31:0] old, logic [31:0] mask);
        case (how)
            COMB_SUM:  return (cur + old) & mask;
            COMB_MEAN: return ((cur + old) >> 1) & mask;
            default:   return cur;
        endcase
    endfunction

    // Extract both fields, place the upper one above the lower width, and
    // optionally merge each with the matching bits of the stored value
    function automatic logic [PACK_W-1:0] pack_fields(logic [WORD_W-1:0] word,
                                                      logic [PACK_W-1:0] old, bit merge);
        int unsigned uw;
        int unsigned lw;
        logic [31:0] ufield;
        logic [31:0] umask;
        logic [31:0] lmask;
        logic [31:0] up;
        logic [31:0] lo;
        uw = (shadow_cfg.upper_width > 5'd16) ? 16 : shadow_cfg.upper_width;
        lw = (shadow_cfg.lower_width > 5'd16) ? 16 : shadow_cfg.lower_width;
        ufield = (32'd1 << uw) - 32'd1;
        umask  = (ufield << lw) & 32'h0000_FFFF;
        lmask  = (32'd1 << lw) - 32'd1;
        up = (((word >> shadow_cfg.upper_first_bit) & ufield) << lw) & 32'h0000_FFFF;
        lo = (word >> shadow_cfg.lower_first_bit) & lmask;
        if (merge) begin
            up = merge_field(shadow_cfg.upper_combine, up, {16'd0, old} & umask, umask);
            lo = merge_field(shadow_cfg.lower_combine, lo, {16'd0, old} & lmask, lmask);
        end
        return PACK_W'(up | lo);
    endfunction

    // Advance the shadow by one accepted pixel beat and queue what it should produce
    task automatic take_sample(logic [WORD_W-1:0] word, logic [INDEX_W-1:0] pix,
                               logic last, logic typed, logic [PACK_W-1:0] want);
        pixel_result_t     due;
        logic [PACK_W-1:0] coadded;
        bit                emit;
        emit = 1'b1;
        coadded = '0;
        if (!shadow_cfg.pair_frames) begin
            pair_second = 1'b0;
            coadded = pack_fields(word, '0, 1'b0);
        end else if (pair_second) begin
            coadded = pack_fields(word, pixel_mem[pix], 1'b1);
            if (last)
                pair_second = 1'b0;
        end else begin
            // first frame of a pair: store only, no result beat
            pixel_mem[pix] = pack_fields(word, '0, 1'b0);
            if (!pix_stored[pix]) begin
                pix_stored[pix] = 1'b1;
                stored_list.push_back(int'(pix));
            end
            if (last)
                pair_second = 1'b1;
            emit = 1'b0;
        end
        if (emit) begin
            due.sample = typed ? want : coadded;
            due.index  = pix;
            due.last   = last;
            coadd_due_q.push_back(due);
        end
    endtask

    // Drive one pixel beat after a random gap and hold it until accepted
    task automatic put_sample(logic [WORD_W-1:0] word, logic [INDEX_W-1:0] pix,
                              logic last, logic typed, logic [PACK_W-1:0] want);
        int gap;
        cfg_we <= 1'b0;
        if ($urandom_range(0, 9) == 0)
            feed_quiet = !feed_quiet;
        gap = feed_quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.sample_word <= word;
        in_bus.pixel_index <= pix;
        in_bus.frame_last  <= last;
        do @(posedge clk); while (!in_bus.ready);
        take_sample(word, pix, last, typed, want);
        fed_count++;
    endtask

    // Drop valid, wait for every due result, then let the pipeline run dry
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (coadd_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t which, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        @(posedge clk);
        case (which)
            REG_UPPER_FIRST_BIT: shadow_cfg.upper_first_bit = val;
            REG_UPPER_WIDTH:     shadow_cfg.upper_width     = val;
            REG_LOWER_FIRST_BIT: shadow_cfg.lower_first_bit = val;
            REG_LOWER_WIDTH:     shadow_cfg.lower_width     = val;
            REG_UPPER_COMBINE:   shadow_cfg.upper_combine   = val[1:0];
            REG_LOWER_COMBINE:   shadow_cfg.lower_combine   = val[1:0];
            REG_PAIR_FRAMES:     shadow_cfg.pair_frames     = val[0];
            default: ;
        endcase
    endtask

    // Pick the settings of one random phase; the first two are the extremes
    task automatic new_settings(int phase_no);
        cfg_t pick;
        if (phase_no == 0) begin
            pick = '{5'd0, 5'd0, 5'd0, 5'd0, COMB_KEEP, COMB_KEEP, 1'b1};
        end else if (phase_no == 1) begin
            pick = '{5'd31, 5'd31, 5'd31, 5'd31, COMB_SPARE, COMB_SPARE, 1'b1};
        end else begin
            pick.upper_first_bit = 5'($urandom_range(0, 31));
            pick.lower_first_bit = 5'($urandom_range(0, 31));
            // mostly legal widths, now and then past the saturation point
            pick.upper_width = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(0, 16));
            pick.lower_width = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(0, 16));
            pick.upper_combine = 2'($urandom_range(0, 3));
            pick.lower_combine = 2'($urandom_range(0, 3));
            pick.pair_frames   = ($urandom_range(0, 3) != 0);
        end
        settle();
        write_reg(REG_UPPER_FIRST_BIT, pick.upper_first_bit);
        write_reg(REG_UPPER_WIDTH,     pick.upper_width);
        write_reg(REG_LOWER_FIRST_BIT, pick.lower_first_bit);
        write_reg(REG_LOWER_WIDTH,     pick.lower_width);
        write_reg(REG_UPPER_COMBINE,   CFG_W'(pick.upper_combine));
        write_reg(REG_LOWER_COMBINE,   CFG_W'(pick.lower_combine));
        write_reg(REG_PAIR_FRAMES,     CFG_W'(pick.pair_frames));
    endtask

    task automatic send_frame(int pix_list [$]);
        foreach (pix_list[j])
            put_sample($urandom(), INDEX_W'(pix_list[j]), (j == pix_list.size() - 1),
                       1'b0, '0);
    endtask

    // One round of frames. With pairing on, most rounds are a first frame
    // followed by a second frame over the same pixels; in the rest the second
    // frame only touches pixels already in the store.
    task automatic feed_frames();
        int run_pix [$];
        int n;
        int base;
        bit contiguous;
        n = $urandom_range(1, 12);
        if (!shadow_cfg.pair_frames) begin
            repeat (n) run_pix.push_back($urandom_range(0, PIXELS - 1));
            send_frame(run_pix);
        end else if (pair_second) begin
            repeat (n) run_pix.push_back(stored_list[$urandom_range(0, stored_list.size() - 1)]);
            send_frame(run_pix);
        end else begin
            base = $urandom_range(0, PIXELS - 1);
            contiguous = ($urandom_range(0, 2) != 0);
            for (int j = 0; j < n; j++)
                run_pix.push_back(contiguous ? (base + j) % PIXELS
                                             : $urandom_range(0, PIXELS - 1));
            send_frame(run_pix);
            if ($urandom_range(0, 4) != 0) begin
                send_frame(run_pix);
            end else begin
                run_pix.delete();
                repeat ($urandom_range(1, 12))
                    run_pix.push_back(stored_list[$urandom_range(0, stored_list.size() - 1)]);
                send_frame(run_pix);
            end
        end
    endtask

    // Result side: stall a random number of cycles before each beat, with
    // stretches of back-to-back acceptance mixed in
    initial begin : result_sink
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if ($urandom_range(0, 9) == 0)
                sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge clk); while (!out_bus.valid);
        end
    end

    // Compare every accepted result beat against the oldest one due
    always @(posedge clk) begin : result_check
        pixel_result_t due;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (coadd_due_q.size() == 0) begin
                $display("%0t: result beat with none due: expected none, got %h/%0d/%0b",
                         $time, out_bus.out_sample, out_bus.out_index, out_bus.out_last);
                fails++;
            end else begin
                due = coadd_due_q.pop_front();
                if (out_bus.out_sample !== due.sample) begin
                    $display("%0t: out_sample expected %h actual %h (pixel %0d)",
                             $time, due.sample, out_bus.out_sample, due.index);
                    fails++;
                end
                if (out_bus.out_index !== due.index) begin
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, due.index, out_bus.out_index);
                    fails++;
                end
                if (out_bus.out_last !== due.last) begin
                    $display("%0t: out_last expected %0b actual %0b (pixel %0d)",
                             $time, due.last, out_bus.out_last, due.index);
                    fails++;
                end
            end
        end
    end

    initial begin : stimulus
        int  target;
        int  phase_no;
        int  phase_start;
        int  budget;
        bit  was_write;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_UPPER_FIRST_BIT;
        cfg_data           <= '0;
        in_bus.valid       <= 1'b0;
        in_bus.sample_word <= '0;
        in_bus.pixel_index <= '0;
        in_bus.frame_last  <= 1'b0;
        // register defaults after reset
        shadow_cfg  = '{5'd16, 5'd16, 5'd0, 5'd0, COMB_KEEP, COMB_KEEP, 1'b1};
        pair_second = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; hold off each group of register writes until the block is idle
        was_write = 1'b0;
        for (int r = 0; r < N_PLAN; r++) begin
            if (PLAN[r].is_write) begin
                if (!was_write)
                    settle();
                write_reg(PLAN[r].wr_reg, PLAN[r].wr_val);
            end else begin
                put_sample(PLAN[r].word, PLAN[r].pix, PLAN[r].last, PLAN[r].typed,
                           PLAN[r].want);
            end
            was_write = PLAN[r].is_write;
        end

        // Random phases: new settings, then rounds of frames until the budget is spent
        target = fed_count + RANDOM_SAMPLES;
        phase_no = 0;
        while (fed_count < target) begin
            new_settings(phase_no);
            budget = $urandom_range(25, 60);
            phase_start = fed_count;
            while ((fed_count - phase_start) < budget && fed_count < target)
                feed_frames();
            phase_no++;
        end

        settle();
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/fpc_pkg.sv
rtl/fpc_in_if.sv
rtl/fpc_out_if.sv
rtl/fpc_field_extract.sv
rtl/frame_pair_field_coadder.sv
bench/tb.sv
